FILE: hdl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants of the script token lexer.
// ----------------------------------------------------------------------------
`default_nettype none
package stl_pkg;
   localparam int TokenCapacity = 256;
   localparam int PosWidth      = 16;
   localparam int LenWidth      = $clog2(TokenCapacity + 1);
   localparam logic [PosWidth-1:0] PosMax = '1;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_TOKEN = 2'd1,
      KIND_ERROR = 2'd2,
      KIND_EOF   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_BAD_CHAR  = 3'd0,
      ERR_STR_LINE  = 3'd1,
      ERR_BAD_ESC   = 3'd2,
      ERR_DOT       = 3'd3,
      ERR_DIGIT     = 3'd4,
      ERR_TOO_LONG  = 3'd5
   } err_type;

   localparam logic [5:0] TYPE_ID  = 6'd0;
   localparam logic [5:0] TYPE_NUM = 6'd1;
   localparam logic [5:0] TYPE_STR = 6'd2;
   localparam logic [5:0] TYPE_KW0 = 6'd26;

   // one source transaction
   typedef struct packed {
      logic [7:0] source_byte;
      logic       at_end;
   } src_item_type;

   // one result transaction
   typedef struct packed {
      logic [1:0]          kind;
      logic [7:0]          text_byte;
      logic [5:0]          token_type;
      logic [PosWidth-1:0] row;
      logic [PosWidth-1:0] col;
      logic [LenWidth-1:0] length;
      logic [2:0]          error_code;
      logic                last;
   } rsp_type;

   // keywords packed as right-aligned byte strings, with their lengths
   localparam int NumKw = 21;
   typedef logic [63:0] kw_word_type;
   localparam kw_word_type KwWord [NumKw] = '{
      64'("nil"), 64'("true"), 64'("false"), 64'("let"), 64'("const"),
      64'("if"), 64'("while"), 64'("for"), 64'("elif"), 64'("else"),
      64'("end"), 64'("do"), 64'("return"), 64'("defer"), 64'("fun"),
      64'("and"), 64'("or"), 64'("not"), 64'("break"), 64'("continue"),
      64'("in")};
   localparam logic [3:0] KwLen [NumKw] = '{
      4'd3, 4'd4, 4'd5, 4'd3, 4'd5, 4'd2, 4'd5, 4'd3, 4'd4, 4'd4, 4'd3,
      4'd2, 4'd6, 4'd5, 4'd3, 4'd3, 4'd2, 4'd3, 4'd5, 4'd8, 4'd2};

   function automatic logic [5:0] single_type(input logic [7:0] c);
      logic [5:0] t;
      case (c)
         8'h28: t = 6'd3;  8'h29: t = 6'd4;  8'h5B: t = 6'd5;
         8'h5D: t = 6'd6;  8'h2C: t = 6'd7;  8'h3B: t = 6'd8;
         8'h2B: t = 6'd9;  8'h2D: t = 6'd11; 8'h2A: t = 6'd13;
         8'h5E: t = 6'd15; 8'h25: t = 6'd16; 8'h3E: t = 6'd17;
         8'h3C: t = 6'd19; 8'h2F: t = 6'd21; 8'h3D: t = 6'd24;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

   function automatic logic [5:0] double_type(input logic [7:0] f, input logic [7:0] c);
      logic [5:0] t;
      t = 6'd0;
      case (f)
         8'h2B: if (c == 8'h2B) t = 6'd10;
         8'h2D: if (c == 8'h2D) t = 6'd12;
         8'h2A: if (c == 8'h2A) t = 6'd14;
         8'h3E: if (c == 8'h3D) t = 6'd18;
         8'h3C: if (c == 8'h3D) t = 6'd20;
         8'h2F: begin
            if (c == 8'h3D) t = 6'd22;
            else if (c == 8'h2F) t = 6'd23;
         end
         8'h3D: if (c == 8'h3D) t = 6'd25;
         default: t = 6'd0;
      endcase
      return t;
   endfunction
endpackage
`default_nettype wire

FILE: hdl/stl_if.sv
// ----------------------------------------------------------------------------
// stl_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface stl_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hdl/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming lexer: source bytes in; token text bytes, token ends, errors and EOF out.
// ----------------------------------------------------------------------------
// One source byte (or end marker) is taken per transaction, one per cycle
// when the result side keeps up. Each byte is lexed combinationally into up
// to three results that are held in a three-entry output buffer; the buffer
// drains one result per cycle when the result side is ready; a byte with two
// or three results holds the input until they drain. Results are registered.
// After an error or end of input the lexer ignores all input until reset.
`default_nettype none
module script_token_lexer
   import stl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   stl_if.sink       req,
   stl_if.source     rsp
);
   typedef enum logic [3:0] {
      M_IDLE, M_COMMENT, M_ID, M_NUM, M_STR, M_STR_ESC, M_OP, M_HALT, M_DONE
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [7:0]          op_ff, op_in;
   logic [63:0]         win_ff, win_in;
   logic [LenWidth-1:0] cnt_ff, cnt_in;
   logic                dot_ff, dot_in;
   logic [PosWidth-1:0] row_ff, row_in, col_ff, col_in;
   logic [PosWidth-1:0] srow_ff, srow_in, scol_ff, scol_in;

   rsp_type    buf_ff [3];
   rsp_type    buf_in [3];
   logic [1:0] nbuf_ff, nbuf_in, head_ff, head_in;

   rsp_type    res [3];
   logic [1:0] nres;

   logic [7:0] c;
   logic       fin;
   logic       take;
   logic       pop;

   assign c   = req.payload.source_byte;
   assign fin = req.payload.at_end;

   // output buffer
   assign rsp.valid   = (nbuf_ff != 2'd0);
   assign rsp.payload = buf_ff[head_ff];
   assign pop         = rsp.valid && rsp.ready;
   assign req.ready   = (nbuf_ff == 2'd0) || (pop && nbuf_ff == 2'd1);
   assign take        = req.valid && req.ready;

   function automatic logic is_digit(input logic [7:0] x);
      return x >= 8'h30 && x <= 8'h39;
   endfunction
   function automatic logic is_alpha(input logic [7:0] x);
      return (x >= 8'h61 && x <= 8'h7A) || (x >= 8'h41 && x <= 8'h5A);
   endfunction

   // per-byte lexing
   always_comb begin
      logic [PosWidth-1:0] r, cl;
      logic [5:0]          t, kt;
      logic [7:0]          v;
      logic                ok, do_idle;
      mode_in = mode_ff; op_in = op_ff; win_in = win_ff; cnt_in = cnt_ff;
      dot_in = dot_ff; row_in = row_ff; col_in = col_ff;
      srow_in = srow_ff; scol_in = scol_ff;
      nres = 2'd0;
      for (int i = 0; i < 3; i++) res[i] = '0;
      r = row_ff; cl = col_ff; t = '0; kt = '0; v = '0; ok = 1'b0;
      do_idle = 1'b0;

      if (mode_ff != M_HALT && mode_ff != M_DONE) begin
         // position update
         if (!fin && c == 8'h0A) begin
            if (r != PosMax) r = r + 1'b1;
            cl = PosWidth'(1);
         end else if (cl != PosMax) cl = cl + 1'b1;
         row_in = r; col_in = cl;

         // keyword lookup
         for (int k = NumKw - 1; k >= 0; k--)
            if (cnt_ff == LenWidth'(KwLen[k]) && win_ff == KwWord[k])
               kt = TYPE_KW0 + 6'(k);

         case (mode_ff)
            M_COMMENT: begin
               if (fin) do_idle = 1'b1;
               else if (c == 8'h0A) mode_in = M_IDLE;
            end
            M_ID: begin
               if (!fin && (is_alpha(c) || is_digit(c) || c == 8'h5F)) ok = 1'b1;
               else begin
                  t = kt; do_idle = 1'b1;
                  res[0].kind = KIND_TOKEN; res[0].token_type = t;
                  res[0].row = srow_ff; res[0].col = scol_ff; res[0].length = cnt_ff;
                  nres = 2'd1; mode_in = M_IDLE;
               end
            end
            M_NUM: begin
               if (!fin && c == 8'h2E) begin
                  if (dot_ff) begin
                     res[0].kind = KIND_ERROR; res[0].error_code = ERR_DOT;
                     res[0].row = r; res[0].col = cl; nres = 2'd1; mode_in = M_HALT;
                  end else begin dot_in = 1'b1; ok = 1'b1; end
               end else if (!fin && is_digit(c)) ok = 1'b1;
               else if (!fin && is_alpha(c)) begin
                  res[0].kind = KIND_ERROR; res[0].error_code = ERR_DIGIT;
                  res[0].row = r; res[0].col = cl; nres = 2'd1; mode_in = M_HALT;
               end else begin
                  res[0].kind = KIND_TOKEN; res[0].token_type = TYPE_NUM;
                  res[0].row = srow_ff; res[0].col = scol_ff; res[0].length = cnt_ff;
                  nres = 2'd1; mode_in = M_IDLE; do_idle = 1'b1;
               end
            end
            M_STR: begin
               if (fin || c == 8'h0A) begin
                  res[0].kind = KIND_ERROR; res[0].error_code = ERR_STR_LINE;
                  res[0].row = r; res[0].col = cl; nres = 2'd1; mode_in = M_HALT;
               end else if (c == 8'h5C) mode_in = M_STR_ESC;
               else if (c == 8'h22) begin
                  res[0].kind = KIND_TOKEN; res[0].token_type = TYPE_STR;
                  res[0].row = srow_ff; res[0].col = scol_ff; res[0].length = cnt_ff;
                  nres = 2'd1; mode_in = M_IDLE;
               end else ok = 1'b1;
            end
            M_STR_ESC: begin
               if (fin || c == 8'h0A) begin
                  res[0].kind = KIND_ERROR; res[0].error_code = ERR_STR_LINE;
                  res[0].row = r; res[0].col = cl; nres = 2'd1; mode_in = M_HALT;
               end else begin
                  ok = 1'b1;
                  case (c)
                     8'h5C: v = 8'h5C; 8'h30: v = 8'd0; 8'h61: v = 8'd7;
                     8'h62: v = 8'd8;  8'h65: v = 8'd27; 8'h66: v = 8'd12;
                     8'h6E: v = 8'd10; 8'h72: v = 8'd13; 8'h74: v = 8'd9;
                     8'h76: v = 8'd11; 8'h22: v = 8'h22;
                     default: ok = 1'b0;
                  endcase
                  if (!ok) begin
                     res[0].kind = KIND_ERROR; res[0].error_code = ERR_BAD_ESC;
                     res[0].row = r; res[0].col = cl; nres = 2'd1; mode_in = M_HALT;
                  end else mode_in = M_STR;
               end
            end
            M_OP: begin
               t = fin ? 6'd0 : double_type(op_ff, c);
               if (t != 6'd0) ok = 1'b1;
               else begin
                  res[0].kind = KIND_TOKEN; res[0].token_type = single_type(op_ff);
                  res[0].row = srow_ff; res[0].col = scol_ff; res[0].length = cnt_ff;
                  nres = 2'd1; mode_in = M_IDLE; do_idle = 1'b1;
               end
            end
            default: do_idle = 1'b1;
         endcase

         // append in a continuing token
         if (ok) begin
            if (mode_ff == M_STR_ESC && c != 8'h5C) ; else v = c;
            if (cnt_ff >= LenWidth'(TokenCapacity)) begin
               res[0] = '0;
               res[0].kind = KIND_ERROR; res[0].error_code = ERR_TOO_LONG;
               res[0].row = r; res[0].col = cl; mode_in = M_HALT;
               nres = 2'd1;
            end else begin
               res[0].kind = KIND_BYTE; res[0].text_byte = v; nres = 2'd1;
               if (cnt_ff < LenWidth'(8)) win_in = {win_ff[55:0], v};
               cnt_in = cnt_ff + 1'b1;
               if (mode_ff == M_OP) begin
                  res[1].kind = KIND_TOKEN; res[1].token_type = t;
                  res[1].row = srow_ff; res[1].col = scol_ff;
                  res[1].length = cnt_ff + 1'b1; nres = 2'd2; mode_in = M_IDLE;
               end
            end
         end

         // idle handling of the byte, after any finished token
         if (do_idle) begin
            mode_in = M_IDLE;
            if (fin) begin
               res[nres].kind = KIND_EOF; res[nres].row = r; res[nres].col = cl;
               nres = nres + 1'b1; mode_in = M_DONE;
            end else if (c == 8'h22) begin
               cnt_in = '0; win_in = '0; dot_in = 1'b0; srow_in = r; scol_in = cl;
               mode_in = M_STR;
            end else if (c == 8'h23) mode_in = M_COMMENT;
            else if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) ;
            else if (single_type(c) != 6'd0 || is_alpha(c) || c == 8'h5F || is_digit(c)) begin
               // new token; its first byte always fits
               srow_in = r; scol_in = cl; dot_in = 1'b0;
               cnt_in = LenWidth'(1); win_in = {56'd0, c};
               res[nres].kind = KIND_BYTE; res[nres].text_byte = c;
               nres = nres + 1'b1;
               if (is_alpha(c) || c == 8'h5F) mode_in = M_ID;
               else if (is_digit(c)) mode_in = M_NUM;
               else if (c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h3E ||
                        c == 8'h3C || c == 8'h2F || c == 8'h3D) begin
                  op_in = c; mode_in = M_OP;
               end else begin
                  res[nres].kind = KIND_TOKEN; res[nres].token_type = single_type(c);
                  res[nres].row = r; res[nres].col = cl;
                  res[nres].length = LenWidth'(1); nres = nres + 1'b1;
               end
            end else begin
               res[nres].kind = KIND_ERROR; res[nres].error_code = ERR_BAD_CHAR;
               res[nres].row = r; res[nres].col = cl; nres = nres + 1'b1;
               mode_in = M_HALT;
            end
         end
         if (nres != 2'd0) res[nres - 1'b1].last = 1'b1;
      end
   end

   // buffer update
   always_comb begin
      buf_in = buf_ff; nbuf_in = nbuf_ff; head_in = head_ff;
      if (pop) begin
         nbuf_in = nbuf_ff - 1'b1; head_in = head_ff + 1'b1;
      end
      if (take) begin
         buf_in  = res; nbuf_in = nres; head_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         mode_ff <= M_IDLE; op_ff <= '0; win_ff <= '0; cnt_ff <= '0;
         dot_ff <= 1'b0; row_ff <= PosWidth'(1); col_ff <= '0;
         srow_ff <= '0; scol_ff <= '0; nbuf_ff <= '0; head_ff <= '0;
      end else begin
         nbuf_ff <= nbuf_in; head_ff <= head_in;
         if (take) begin
            mode_ff <= mode_in; op_ff <= op_in; win_ff <= win_in; cnt_ff <= cnt_in;
            dot_ff <= dot_in; row_ff <= row_in; col_ff <= col_in;
            srow_ff <= srow_in; scol_ff <= scol_in;
         end
      end
   end
endmodule
`default_nettype wire

FILE: test/script_token_lexer_tb.sv
// ----------------------------------------------------------------------------
// script_token_lexer_tb
// Self-checking bench: a directed table of source bytes, then random token
// streams, each transaction predicted by a behavioral lexer and compared
// field by field against the result channel.
// ----------------------------------------------------------------------------
`default_nettype none
module script_token_lexer_tb
   import stl_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 400000;
   localparam int RandItems  = 260;

   typedef enum logic [3:0] {
      LX_IDLE, LX_COMMENT, LX_ID, LX_NUM, LX_STR, LX_STR_ESC, LX_OP, LX_HALT, LX_DONE
   } lex_state_type;

   typedef enum logic [5:0] {
      TK_ID = 6'd0, TK_NUM, TK_STR, TK_LPAREN, TK_RPAREN, TK_LBRACK, TK_RBRACK,
      TK_COMMA, TK_SEMI, TK_PLUS, TK_INC, TK_MINUS, TK_DEC, TK_STAR, TK_POW,
      TK_CARET, TK_PERCENT, TK_GT, TK_GE, TK_LT, TK_LE, TK_SLASH, TK_SLASH_EQ,
      TK_SLASH2, TK_ASSIGN, TK_EQ, TK_KW_NIL
   } tok_type;

   typedef enum int {
      END_MARKER, END_BAD_CHAR, END_STR_LINE, END_BAD_ESC, END_DOT, END_DIGIT,
      END_TOO_LONG
   } ending_type;

   typedef struct {
      logic [7:0] c;
      bit         fin;
      bit         chk;
      kind_type   k;
      logic [5:0] t;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stl_if #(.payload_type(src_item_type)) req_if (clock);
   stl_if #(.payload_type(rsp_type))      rsp_if (clock);

   script_token_lexer dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   always #4 clock = ~clock;

   // lexer model state
   lex_state_type     lx_state;
   logic [7:0]        op_first;
   logic [63:0]       kw_window;
   int                tok_len;
   bit                dot_seen;
   logic [15:0]       pos_row, pos_col, tok_row, tok_col;
   rsp_type           step_results[$];
   rsp_type           pending_rsps[$];
   src_item_type      stim[$];
   int                failures = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   longint            cycles = 0;

   string kw_names[21] = '{"nil", "true", "false", "let", "const", "if", "while",
      "for", "elif", "else", "end", "do", "return", "defer", "fun", "and", "or",
      "not", "break", "continue", "in"};

   function automatic void put_rsp(kind_type k, logic [7:0] b, logic [5:0] t,
                                   logic [15:0] r, logic [15:0] c, int n,
                                   logic [2:0] e);
      rsp_type x;
      if (step_results.size() >= 3) return;
      x = '0;
      x.kind = k;
      x.text_byte = b;
      x.token_type = t;
      x.row = r;
      x.col = c;
      x.length = n[LenWidth-1:0];
      x.error_code = e;
      step_results.push_back(x);
   endfunction

   function automatic void lex_fail(err_type e);
      put_rsp(KIND_ERROR, 0, 0, pos_row, pos_col, 0, e);
      lx_state = LX_HALT;
   endfunction

   function automatic bit add_char(logic [7:0] c);
      if (tok_len >= TokenCapacity) begin
         lex_fail(ERR_TOO_LONG);
         return 1'b0;
      end
      put_rsp(KIND_BYTE, c, 0, 0, 0, 0, 0);
      if (tok_len < 8) kw_window = {kw_window[55:0], c};
      tok_len++;
      return 1'b1;
   endfunction

   function automatic void close_token(logic [5:0] t);
      put_rsp(KIND_TOKEN, 0, t, tok_row, tok_col, tok_len, 0);
      lx_state = LX_IDLE;
   endfunction

   function automatic void open_token();
      tok_len = 0;
      kw_window = '0;
      dot_seen = 1'b0;
      tok_row = pos_row;
      tok_col = pos_col;
   endfunction

   function automatic logic [5:0] ident_kind();
      logic [63:0] w;
      if (tok_len > 8) return TK_ID;
      for (int i = 0; i < 21; i++) begin
         w = '0;
         for (int j = 0; j < kw_names[i].len(); j++) w = {w[55:0], kw_names[i][j]};
         if (kw_names[i].len() == tok_len && w == kw_window) return 6'(TK_KW_NIL + i);
      end
      return TK_ID;
   endfunction

   function automatic logic [5:0] op_one(logic [7:0] c);
      case (c)
         "(": return TK_LPAREN;   ")": return TK_RPAREN;
         "[": return TK_LBRACK;   "]": return TK_RBRACK;
         ",": return TK_COMMA;    ";": return TK_SEMI;
         "+": return TK_PLUS;     "-": return TK_MINUS;
         "*": return TK_STAR;     "^": return TK_CARET;
         "%": return TK_PERCENT;  ">": return TK_GT;
         "<": return TK_LT;       "/": return TK_SLASH;
         "=": return TK_ASSIGN;
         default: return TK_ID;
      endcase
   endfunction

   function automatic logic [5:0] op_two(logic [7:0] f, logic [7:0] c);
      if (f == "+" && c == "+") return TK_INC;
      if (f == "-" && c == "-") return TK_DEC;
      if (f == "*" && c == "*") return TK_POW;
      if (f == ">" && c == "=") return TK_GE;
      if (f == "<" && c == "=") return TK_LE;
      if (f == "/" && c == "=") return TK_SLASH_EQ;
      if (f == "/" && c == "/") return TK_SLASH2;
      if (f == "=" && c == "=") return TK_EQ;
      return TK_ID;
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // lexing from the idle state
   function automatic void lex_fresh(bit fin, logic [7:0] c);
      lx_state = LX_IDLE;
      if (fin) begin
         put_rsp(KIND_EOF, 0, 0, pos_row, pos_col, 0, 0);
         lx_state = LX_DONE;
         return;
      end
      case (c)
         "(", ")", "[", "]", ",", ";", "^", "%": begin
            open_token();
            if (add_char(c)) close_token(op_one(c));
         end
         "+", "-", "*", ">", "<", "/", "=": begin
            open_token();
            if (add_char(c)) begin
               op_first = c;
               lx_state = LX_OP;
            end
         end
         "\"": begin
            open_token();
            lx_state = LX_STR;
         end
         "#": lx_state = LX_COMMENT;
         default: begin
            if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
            if (is_letter(c) || c == "_") begin
               open_token();
               if (add_char(c)) lx_state = LX_ID;
            end else if (is_num(c)) begin
               open_token();
               if (add_char(c)) lx_state = LX_NUM;
            end else begin
               lex_fail(ERR_BAD_CHAR);
            end
         end
      endcase
   endfunction

   function automatic logic [8:0] escape_code(logic [7:0] c);
      case (c)
         "0": return 9'h100;  "a": return 9'h107;  "b": return 9'h108;
         "e": return 9'h11B;  "f": return 9'h10C;  "n": return 9'h10A;
         "r": return 9'h10D;  "t": return 9'h109;  "v": return 9'h10B;
         "\"": return 9'h122;
         default: return 9'h000;
      endcase
   endfunction

   // predict the results of one accepted source transaction
   function automatic void lex_predict(src_item_type it);
      logic [7:0] c;
      bit         fin;
      logic [5:0] t;
      logic [8:0] esc;
      c = it.source_byte;
      fin = it.at_end;
      step_results.delete();
      if (lx_state == LX_HALT || lx_state == LX_DONE) return;
      if (!fin && c == "\n") begin
         if (pos_row != PosMax) pos_row++;
         pos_col = 1;
      end else if (pos_col != PosMax) begin
         pos_col++;
      end
      case (lx_state)
         LX_COMMENT: begin
            if (fin) lex_fresh(1'b1, 0);
            else if (c == "\n") lx_state = LX_IDLE;
         end
         LX_ID: begin
            if (!fin && (is_letter(c) || is_num(c) || c == "_")) void'(add_char(c));
            else begin
               close_token(ident_kind());
               lex_fresh(fin, c);
            end
         end
         LX_NUM: begin
            if (!fin && c == ".") begin
               if (dot_seen) lex_fail(ERR_DOT);
               else begin
                  dot_seen = 1'b1;
                  void'(add_char(c));
               end
            end else if (!fin && is_num(c)) void'(add_char(c));
            else if (!fin && is_letter(c)) lex_fail(ERR_DIGIT);
            else begin
               close_token(TK_NUM);
               lex_fresh(fin, c);
            end
         end
         LX_STR: begin
            if (fin || c == "\n") lex_fail(ERR_STR_LINE);
            else if (c == "\\") lx_state = LX_STR_ESC;
            else if (c == "\"") close_token(TK_STR);
            else void'(add_char(c));
         end
         LX_STR_ESC: begin
            esc = escape_code(c);
            if (fin || c == "\n") lex_fail(ERR_STR_LINE);
            else if (c == "\\") begin
               if (add_char(c)) lx_state = LX_STR;
            end else if (esc[8]) begin
               if (add_char(esc[7:0])) lx_state = LX_STR;
            end else lex_fail(ERR_BAD_ESC);
         end
         LX_OP: begin
            t = fin ? TK_ID : op_two(op_first, c);
            if (t != TK_ID) begin
               if (add_char(c)) close_token(t);
            end else begin
               close_token(op_one(op_first));
               lex_fresh(fin, c);
            end
         end
         default: lex_fresh(fin, c);
      endcase
      if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
      foreach (step_results[i]) pending_rsps.push_back(step_results[i]);
   endfunction

   // stimulus building
   function automatic void push_byte(logic [7:0] c);
      src_item_type it;
      it.source_byte = c;
      it.at_end = 1'b0;
      stim.push_back(it);
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   // one random well-formed token, comment or whitespace, followed by a separator
   function automatic void add_random_token();
      string ops[] = '{"(", ")", "[", "]", ",", ";", "^", "%", "+", "++", "-", "--",
                       "*", "**", ">", ">=", "<", "<=", "/", "/=", "//", "=", "=="};
      string idc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      logic [7:0] c;
      int n;
      case ($urandom_range(5))
         0: begin
            if ($urandom_range(1)) push_text(kw_names[$urandom_range(20)]);
            else begin
               push_byte(pick("abcxyzQZ_"));
               n = $urandom_range(11);
               repeat (n) push_byte(pick(idc));
            end
         end
         1: begin
            n = $urandom_range(1, 5);
            repeat (n) push_byte(pick("0123456789"));
            if ($urandom_range(1)) begin
               push_byte(".");
               n = $urandom_range(3);
               repeat (n) push_byte(pick("0123456789"));
            end
         end
         2: begin
            push_byte("\"");
            n = $urandom_range(6);
            repeat (n) begin
               if ($urandom_range(3) == 0) begin
                  push_byte("\\");
                  push_byte(pick("0abefnrtv\"\\"));
               end else begin
                  do c = 8'($urandom_range(1, 255));
                  while (c == "\n" || c == "\"" || c == "\\");
                  push_byte(c);
               end
            end
            push_byte("\"");
         end
         3: push_text(ops[$urandom_range(ops.size() - 1)]);
         4: begin
            push_byte("#");
            n = $urandom_range(4);
            repeat (n) push_byte(8'($urandom_range(0, 255) & 8'hF7 | 8'h01));
            push_byte("\n");
         end
         default: push_byte(pick(" \t\n\v\f\r"));
      endcase
      push_byte(pick("  \t\n"));
   endfunction

   // the one error or end marker that stops the lexer
   function automatic void add_ending();
      ending_type e;
      src_item_type it;
      e = ending_type'($urandom_range(6));
      push_byte("\n");
      case (e)
         END_BAD_CHAR: push_byte(pick("@$`~!?\\'{}|&:\x00\x80\xff"));
         END_STR_LINE: push_text("\"ab\n");
         END_BAD_ESC:  push_text("\"a\\q");
         END_DOT:      push_text("1.2.");
         END_DIGIT:    push_text("12a");
         END_TOO_LONG: begin
            push_byte("\"");
            repeat (TokenCapacity + 1) push_byte(pick("xyz019 "));
         end
         default: ;
      endcase
      it.source_byte = 8'($urandom_range(255));
      it.at_end = 1'b1;
      if (e == END_MARKER) stim.push_back(it);
      // after the stop, items are ignored
      repeat (3) stim.push_back(it);
   endfunction

   // directed table
   table_row_type dir_rows[] = '{
      '{"l", 0, 0, KIND_BYTE, 0}, '{"e", 0, 0, KIND_BYTE, 0}, '{"t", 0, 0, KIND_BYTE, 0},
      '{" ", 0, 1, KIND_TOKEN, 6'd29},
      '{"_", 0, 1, KIND_BYTE, 0}, '{"a", 0, 0, KIND_BYTE, 0}, '{"9", 0, 0, KIND_BYTE, 0},
      '{"=", 0, 1, KIND_TOKEN, TK_ID}, '{"=", 0, 1, KIND_BYTE, 0},
      '{"\"", 0, 0, KIND_BYTE, 0}, '{8'hFF, 0, 1, KIND_BYTE, 0},
      '{8'h01, 0, 1, KIND_BYTE, 0}, '{"\\", 0, 0, KIND_BYTE, 0},
      '{"e", 0, 1, KIND_BYTE, 0}, '{"\"", 0, 1, KIND_TOKEN, TK_STR},
      '{"\n", 0, 0, KIND_BYTE, 0}, '{"9", 0, 1, KIND_BYTE, 0},
      '{".", 0, 0, KIND_BYTE, 0}, '{"0", 0, 0, KIND_BYTE, 0},
      '{")", 0, 1, KIND_TOKEN, TK_NUM}, '{"#", 0, 0, KIND_BYTE, 0},
      '{8'h80, 0, 0, KIND_BYTE, 0}, '{"\n", 0, 0, KIND_BYTE, 0},
      '{"\t", 0, 0, KIND_BYTE, 0}};

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   // result side: random stalls and transaction checking
   always @(posedge clock) begin
      rsp_type want, got;
      cycles <= cycles + 1;
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (pending_rsps.size() == 0) begin
            $error("unexpected result transaction, kind %0d", got.kind);
            failures++;
         end else begin
            want = pending_rsps.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("text_byte", want.text_byte, got.text_byte);
            check_field("token_type", want.token_type, got.token_type);
            check_field("row", want.row, got.row);
            check_field("col", want.col, got.col);
            check_field("length", want.length, got.length);
            check_field("error_code", want.error_code, got.error_code);
            check_field("last", want.last, got.last);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("** script_token_lexer: FAILED **");
         $finish;
      end
   end

   initial begin
      int n, phase, dir_count;
      src_item_type it;
      src_item_type tail[$];
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      lx_state = LX_IDLE;
      op_first = '0;
      kw_window = '0;
      tok_len = 0;
      dot_seen = 1'b0;
      pos_row = 16'd1;
      pos_col = '0;
      tok_row = '0;
      tok_col = '0;

      foreach (dir_rows[i]) begin
         it.source_byte = dir_rows[i].c;
         it.at_end = dir_rows[i].fin;
         stim.push_back(it);
      end
      dir_count = dir_rows.size();
      // the ending counts toward the item budget
      add_ending();
      for (int j = dir_count; j < stim.size(); j++) tail.push_back(stim[j]);
      while (stim.size() > dir_count) void'(stim.pop_back());
      while (stim.size() + tail.size() < dir_count + RandItems) add_random_token();
      foreach (tail[j]) stim.push_back(tail[j]);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      n = stim.size();
      phase = 0;
      for (int i = 0; i < n; i++) begin
         // phase changes: drain everything first, then new idle rates
         if (i * 3 / n != phase || i == 0) begin
            if (i != 0) begin
               req_if.valid <= 1'b0;
               @(posedge clock);
               while (pending_rsps.size() != 0) @(posedge clock);
            end
            phase = i * 3 / n;
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 9 : 0;
         end
         if ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
            while ($urandom_range(99) < send_idle_pct) @(posedge clock);
         end
         req_if.valid <= 1'b1;
         req_if.payload <= stim[i];
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
         lex_predict(stim[i]);
         if (i < dir_count && dir_rows[i].chk) begin
            if (step_results.size() == 0) begin
               $error("kind mismatch: expected %0d, actual none", dir_rows[i].k);
               failures++;
            end else begin
               check_field("kind", dir_rows[i].k, step_results[0].kind);
               check_field("token_type", dir_rows[i].t, step_results[0].token_type);
            end
         end
      end
      req_if.valid <= 1'b0;

      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && pending_rsps.size() == 0) begin
         $display("** script_token_lexer: PASSED **");
      end else begin
         $display("** script_token_lexer: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire
